@@ hw/rtl/msq_pkg.sv @@
// Shared constants and types for the maximal-square line processor.
// No dependencies; every other file in this block refers to it by scoped names.
`default_nettype none

package msq_pkg;

	// Widest row the line store holds
	localparam int MaxCols = 1024;
	localparam int ColW    = $clog2(MaxCols);
	localparam int LenW    = $clog2(MaxCols + 1);

	localparam int CfgW  = 11;
	localparam int SideW = 11;
	localparam int AreaW = 21;

	// Row-length compares run at the wider of the register and the length range
	localparam int CmpW = (LenW > CfgW) ? LenW : CfgW;

	localparam logic [SideW-1:0] SideMax     = {SideW{1'b1}};
	localparam logic [AreaW-1:0] AreaMax     = {AreaW{1'b1}};
	localparam logic [CfgW-1:0]  RowLenReset = CfgW'(1024);

	// Control that travels with a cell from the issue stage into the compute stage
	typedef struct packed {
		logic valid;
		logic last;
		logic first_row;
		logic col_zero;
		logic filled;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/maximal_square_dp.sv @@
// Maximal all-ones square over a binary matrix streamed one cell per request in
// row-major order, row length set by the cfg register (0 acts as 1, above the
// line store depth acts as the depth). For each accepted cell the
// issue stage sends the column address to a 1024 x 11 one-row line store, whose
// registered read returns the cell's up value; the compute stage forms
// min(up, left, diagonal) + 1 (0 if empty), stores it, updates the running best.
// A same-column read and write in one cycle (row length 1) is bypassed in the
// line store. The store gets no clearing pass: the first row of every matrix
// reads its up values as zero. On the request marked last the result (best side
// and its saturated square) passes from the compute stage through the area stage
// into the output register, and the matrix state is cleared. One result may
// wait at the output and one more in the area stage while cells keep streaming;
// input ready drops only when both are full. Depends on msq_pkg.
// Configuration: write row_length only while no request is in flight.
`default_nettype none

module maximal_square_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [msq_pkg::CfgW-1:0]  cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      cell_bit,
	input  wire logic                      last_cell,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [msq_pkg::SideW-1:0] largest_side,
	output logic      [msq_pkg::AreaW-1:0] largest_area
);

	// Issue-stage state
	logic [msq_pkg::CfgW-1:0] row_length_q;
	logic [msq_pkg::ColW-1:0] column_q;
	logic                     first_row_q;

	// Compute-stage pipeline registers
	msq_pkg::cell_ctrl_t      ctrl_s1;
	logic [msq_pkg::ColW-1:0] col_s1;

	logic                      stall;
	logic                      adv;
	logic                      accept;
	logic [msq_pkg::CmpW-1:0]  len_raw;
	logic [msq_pkg::CmpW-1:0]  len_eff;
	logic                      wrap_in;
	logic [msq_pkg::ColW-1:0]  col;
	logic                      first_row;
	logic [msq_pkg::CmpW-1:0]  col_next;
	logic [msq_pkg::SideW-1:0] up_raw;
	logic [msq_pkg::SideW-1:0] side;
	logic [msq_pkg::SideW-1:0] best_side;

	assign cfg_ready = 1'b1;
	assign adv       = !stall;
	assign in_ready  = adv;
	assign accept    = in_valid && adv;

	// Clamp the row length into 1..line store depth
	always_comb begin
		len_raw = msq_pkg::CmpW'(row_length_q);
		if (len_raw == '0) begin
			len_eff = msq_pkg::CmpW'(1);
		end else if (len_raw > msq_pkg::CmpW'(msq_pkg::MaxCols)) begin
			len_eff = msq_pkg::CmpW'(msq_pkg::MaxCols);
		end else begin
			len_eff = len_raw;
		end
	end

	// Column of this cell: a row shortened mid-way ends here and a new row starts
	always_comb begin
		wrap_in   = msq_pkg::CmpW'(column_q) >= len_eff;
		col       = wrap_in ? '0 : column_q;
		first_row = first_row_q && !wrap_in;
		col_next  = msq_pkg::CmpW'(col) + msq_pkg::CmpW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= msq_pkg::RowLenReset;
			column_q     <= '0;
			first_row_q  <= 1'b1;
			ctrl_s1      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				row_length_q <= cfg_data;
			end
			if (adv) begin
				ctrl_s1.valid     <= accept;
				ctrl_s1.last      <= last_cell;
				ctrl_s1.first_row <= first_row;
				ctrl_s1.col_zero  <= (col == '0);
				ctrl_s1.filled    <= cell_bit;
			end
			if (accept) begin
				if (last_cell) begin
					// End of matrix: start the next one at its top-left cell
					column_q    <= '0;
					first_row_q <= 1'b1;
				end else if (col_next >= len_eff) begin
					column_q    <= '0;
					first_row_q <= 1'b0;
				end else begin
					column_q    <= msq_pkg::ColW'(col_next);
					first_row_q <= first_row;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1 <= col;
		end
	end

	msq_line_buf u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (adv && ctrl_s1.valid),
		.wr_addr (col_s1),
		.wr_data (side),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (up_raw)
	);

	msq_cell_pe u_cell_pe (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctrl_s1   (ctrl_s1),
		.up_raw    (up_raw),
		.side      (side),
		.best_side (best_side)
	);

	msq_out_stage u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (ctrl_s1.valid && ctrl_s1.last),
		.push_side    (best_side),
		.stall        (stall),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.largest_side (largest_side),
		.largest_area (largest_area)
	);

endmodule

`default_nettype wire

@@ hw/rtl/msq_line_buf.sv @@
// One-row line store of side values: synchronous memory, one write and one read
// per cycle, registered read data with write-first bypass. Uses msq_pkg.
`default_nettype none

module msq_line_buf (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [msq_pkg::ColW-1:0]  wr_addr,
	input  wire logic [msq_pkg::SideW-1:0] wr_data,
	input  wire logic                      rd_en,
	input  wire logic [msq_pkg::ColW-1:0]  rd_addr,
	output logic      [msq_pkg::SideW-1:0] rd_data
);

	logic [msq_pkg::SideW-1:0] mem [msq_pkg::MaxCols];
	logic [msq_pkg::SideW-1:0] mem_q;
	logic [msq_pkg::SideW-1:0] byp_data_q;
	logic                      byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q      <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// Same-address read and write in one cycle: take the new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : mem_q;

endmodule

`default_nettype wire

@@ hw/rtl/msq_cell_pe.sv @@
// Compute stage: min(up, left, diag) + 1 (0 if empty), running best side.
// Uses msq_pkg for widths and the stage control struct.
`default_nettype none

module msq_cell_pe (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire msq_pkg::cell_ctrl_t       ctrl_s1,
	input  wire logic [msq_pkg::SideW-1:0] up_raw,
	output logic      [msq_pkg::SideW-1:0] side,
	output logic      [msq_pkg::SideW-1:0] best_side
);

	logic [msq_pkg::SideW-1:0] left_q;
	logic [msq_pkg::SideW-1:0] diag_q;
	logic [msq_pkg::SideW-1:0] best_q;
	logic [msq_pkg::SideW-1:0] up;
	logic [msq_pkg::SideW-1:0] left;
	logic [msq_pkg::SideW-1:0] diag;
	logic [msq_pkg::SideW-1:0] min_ul;
	logic [msq_pkg::SideW-1:0] min_all;

	always_comb begin
		up      = ctrl_s1.first_row ? '0 : up_raw;
		left    = ctrl_s1.col_zero ? '0 : left_q;
		diag    = (ctrl_s1.first_row || ctrl_s1.col_zero) ? '0 : diag_q;
		min_ul  = (up < left) ? up : left;
		min_all = (min_ul < diag) ? min_ul : diag;
		if (!ctrl_s1.filled) begin
			side = '0;
		end else if (min_all == msq_pkg::SideMax) begin
			side = msq_pkg::SideMax;
		end else begin
			side = min_all + msq_pkg::SideW'(1);
		end
		best_side = (side > best_q) ? side : best_q;
	end

	// Advance neighbor and best registers; drop them at the end of a matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			diag_q <= '0;
			best_q <= '0;
		end else if (adv && ctrl_s1.valid) begin
			if (ctrl_s1.last) begin
				left_q <= '0;
				diag_q <= '0;
				best_q <= '0;
			end else begin
				left_q <= side;
				diag_q <= up;
				best_q <= best_side;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/msq_out_stage.sv @@
// Result path: area stage (registered square with saturation) and output register.
// Uses msq_pkg for widths and saturation limits.
`default_nettype none

module msq_out_stage (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic [msq_pkg::SideW-1:0] push_side,
	output logic                           stall,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [msq_pkg::SideW-1:0] largest_side,
	output logic      [msq_pkg::AreaW-1:0] largest_area
);

	logic                        valid_s2;
	logic [msq_pkg::SideW-1:0]   side_s2;
	logic                        out_valid_q;
	logic [msq_pkg::SideW-1:0]   side_q;
	logic [msq_pkg::AreaW-1:0]   area_q;
	logic [2*msq_pkg::SideW-1:0] square;
	logic                        move_s2;

	assign square  = side_s2 * side_s2;
	assign move_s2 = valid_s2 && (!out_valid_q || out_ready);
	assign stall   = valid_s2 && !move_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!stall) begin
				valid_s2 <= push;
			end
			if (move_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			side_s2 <= push_side;
		end
		if (move_s2) begin
			side_q <= side_s2;
			area_q <= (square > (2*msq_pkg::SideW)'(msq_pkg::AreaMax))
				? msq_pkg::AreaMax : msq_pkg::AreaW'(square);
		end
	end

	assign out_valid    = out_valid_q;
	assign largest_side = side_q;
	assign largest_area = area_q;

endmodule

`default_nettype wire
